@@ rtl/sdmp_pkg.sv @@
package sdmp_pkg;

	// Framing characters and the id bias
	localparam logic [7:0] CH_OPEN  = 8'h3C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CLOSE = 8'h3E;
	localparam logic [7:0] ID_BIAS  = 8'd48;

	// Input commands
	localparam logic CMD_PARSE   = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Buffer write kinds
	localparam logic [1:0] WK_NONE  = 2'd0;
	localparam logic [1:0] WK_CMD   = 2'd1;
	localparam logic [1:0] WK_FIELD = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] write_kind;
		logic [2:0] field_index;
		logic [3:0] write_offset;
		logic [7:0] write_data;
		logic [7:0] source_id;
		logic [7:0] dest_id;
		logic       done_res;
		logic       overflow;
	} rsp_t;

endpackage

@@ rtl/sdmp_core.sv @@
module sdmp_core import sdmp_pkg::*; #(
	parameter int CMD_LEN    = 16,
	parameter int FIELD_LEN  = 16,
	parameter int MAX_FIELDS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t req,
	output rsp_t rsp
);

	localparam int MAX_LEN = (CMD_LEN > FIELD_LEN) ? CMD_LEN : FIELD_LEN;
	localparam int OFS_W   = $clog2(MAX_LEN);
	localparam int FLD_W   = $clog2(MAX_FIELDS + 1);

	localparam logic [OFS_W-1:0] CMD_LAST   = OFS_W'(CMD_LEN - 1);
	localparam logic [OFS_W-1:0] FIELD_LAST = OFS_W'(FIELD_LEN - 1);
	localparam logic [FLD_W-1:0] FLD_FULL   = FLD_W'(MAX_FIELDS);

	typedef enum logic [2:0] {
		PH_START,
		PH_COMMAND,
		PH_SOURCE,
		PH_DEST,
		PH_FIELD,
		PH_DONE
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [OFS_W-1:0] ofs_q, ofs_d;
	logic [FLD_W-1:0] fld_q, fld_d;
	logic [7:0]       src_q, src_d;
	logic [7:0]       dst_q, dst_d;
	rsp_t             rsp_q, rsp_d;

	logic             room_field;
	logic [OFS_W+3:0] ofs_ext;
	logic [FLD_W+2:0] fld_ext;

	assign room_field = (fld_q < FLD_FULL);
	assign ofs_ext    = {4'b0, ofs_q};
	assign fld_ext    = {3'b0, fld_q};

	always_comb begin
		phase_d = phase_q;
		ofs_d   = ofs_q;
		fld_d   = fld_q;
		src_d   = src_q;
		dst_d   = dst_q;
		rsp_d   = '0;

		if (req.cmd == CMD_RESTART) begin
			phase_d = PH_START;
			ofs_d   = '0;
			fld_d   = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (req.data_byte == CH_OPEN)
						phase_d = PH_COMMAND;
				end
				PH_COMMAND: begin
					if (req.data_byte == CH_SLASH) begin
						// terminator always fits
						rsp_d.write_kind   = WK_CMD;
						rsp_d.write_offset = ofs_ext[3:0];
						ofs_d              = '0;
						phase_d            = PH_SOURCE;
					end else if (ofs_q >= CMD_LAST) begin
						rsp_d.overflow = 1'b1;
					end else begin
						rsp_d.write_kind   = WK_CMD;
						rsp_d.write_offset = ofs_ext[3:0];
						rsp_d.write_data   = req.data_byte;
						ofs_d              = ofs_q + 1'b1;
					end
				end
				PH_SOURCE: begin
					src_d   = req.data_byte - ID_BIAS;
					phase_d = PH_DEST;
				end
				PH_DEST: begin
					if (req.data_byte == CH_SLASH)
						phase_d = PH_FIELD;
					else if (req.data_byte == CH_CLOSE)
						phase_d = PH_DONE;
					else
						dst_d = req.data_byte - ID_BIAS;
				end
				PH_FIELD: begin
					if (req.data_byte == CH_SLASH || req.data_byte == CH_CLOSE) begin
						if (room_field) begin
							rsp_d.write_kind   = WK_FIELD;
							rsp_d.field_index  = fld_ext[2:0];
							rsp_d.write_offset = ofs_ext[3:0];
						end else begin
							rsp_d.overflow = 1'b1;
						end
						if (req.data_byte == CH_SLASH) begin
							if (room_field)
								fld_d = fld_q + 1'b1;
							ofs_d = '0;
						end else begin
							phase_d = PH_DONE;
						end
					end else if (!room_field || ofs_q >= FIELD_LAST) begin
						rsp_d.overflow = 1'b1;
					end else begin
						rsp_d.write_kind   = WK_FIELD;
						rsp_d.field_index  = fld_ext[2:0];
						rsp_d.write_offset = ofs_ext[3:0];
						rsp_d.write_data   = req.data_byte;
						ofs_d              = ofs_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		rsp_d.source_id = src_d;
		rsp_d.dest_id   = dst_d;
		rsp_d.done_res  = (phase_d == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			ofs_q   <= '0;
			fld_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			rsp_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ofs_q   <= ofs_d;
			fld_q   <= fld_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			rsp_q   <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/slash_delimited_message_parser.sv @@
// Parser for framed messages of the form <command/SD/field/field...>.
//
// Request channel (req_valid, req_ready, req): one transaction carries either
// a message byte or a restart command. Response channel (rsp_valid, rsp_ready,
// rsp): exactly one transaction per request, describing the buffer write the
// byte causes (command or field character, or a zero terminator), the latest
// source and destination ids, the done flag and the overflow flag. The
// command and field buffers themselves live downstream.
//
// The response is registered: the response for a request accepted at an edge is
// valid after that edge. Throughput is one transaction per cycle while the
// receiver takes each response; the whole parse step is a single pass of logic
// from the parser state registers into the response register.
//
// Reset clears the parser to "waiting for <", offset and field index to zero
// and both ids to zero; no response is pending after reset.
//
// When the receiver stalls, the response register holds its transaction and
// req_ready drops, so upstream waits; as soon as the response is taken a new
// request may enter in the same cycle.
module slash_delimited_message_parser import sdmp_pkg::*; #(
	parameter int CMD_LEN    = 16,
	parameter int FIELD_LEN  = 16,
	parameter int MAX_FIELDS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic rsp_valid_q;
	logic step;

	// Accept whenever the response slot is empty or is being drained now
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign step      = req_valid && req_ready;

	// Parser state and response register; advance only on an accepted request
	sdmp_core #(
		.CMD_LEN   (CMD_LEN),
		.FIELD_LEN (FIELD_LEN),
		.MAX_FIELDS(MAX_FIELDS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.req   (req),
		.rsp   (rsp)
	);

	// Hold valid until the response is taken; refill it on a new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ tb/slash_delimited_message_parser_tb.sv @@
module slash_delimited_message_parser_tb import sdmp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CMD_LEN    = 16;
	localparam int FIELD_LEN  = 16;
	localparam int MAX_FIELDS = 8;

	// Stimulus volume and idling shape
	localparam int MSG_ITEMS   = 1800;
	localparam int HOLD_AT     = 400;   // responses taken before the long receiver hold
	localparam int HOLD_LEN    = 300;   // cycles the receiver refuses during that hold
	localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction before giving up
	localparam int DRAIN_SLACK = 4;     // extra cycles to wait after the drain

	typedef enum logic [2:0] {
		WAIT_OPEN,
		IN_COMMAND,
		IN_SOURCE,
		IN_DEST,
		IN_FIELDS,
		FINISHED
	} phase_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Parser state as this bench tracks it
	phase_e     msg_phase = WAIT_OPEN;
	logic [3:0] buf_offset = '0;
	logic [3:0] field_no = '0;
	logic [7:0] src_id = '0;
	logic [7:0] dst_id = '0;

	req_t pending_req[$];
	rsp_t expected_rsp[$];

	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned hold_left;
	bit          hold_done;
	int unsigned rsp_seen;
	int unsigned idle_cycles;
	int unsigned cyc;
	int unsigned errors;
	logic        calm;

	slash_delimited_message_parser #(
		.CMD_LEN   (CMD_LEN),
		.FIELD_LEN (FIELD_LEN),
		.MAX_FIELDS(MAX_FIELDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Turn off idling on both sides for a stretch of every window, so that
	// back-to-back transactions get exercised too.
	assign calm = (cyc % 1200) < 250;

	// Advance the parse state by one request and return the buffer write,
	// ids and flags that the block must report for it.
	function automatic rsp_t parse_step(req_t r);
		rsp_t o;
		logic room;
		logic delim;
		o = '0;
		room = field_no < MAX_FIELDS;
		delim = (r.data_byte == CH_SLASH) || (r.data_byte == CH_CLOSE);
		if (r.cmd == CMD_RESTART) begin
			// Restart keeps both ids
			msg_phase = WAIT_OPEN;
			buf_offset = '0;
			field_no = '0;
		end else begin
			case (msg_phase)
				WAIT_OPEN: begin
					if (r.data_byte == CH_OPEN)
						msg_phase = IN_COMMAND;
				end
				IN_COMMAND: begin
					if (r.data_byte == CH_SLASH) begin
						// Terminator always fits at the current offset
						o.write_kind = WK_CMD;
						o.write_offset = buf_offset;
						buf_offset = '0;
						msg_phase = IN_SOURCE;
					end else if (buf_offset >= CMD_LEN - 1) begin
						o.overflow = 1'b1;
					end else begin
						o.write_kind = WK_CMD;
						o.write_offset = buf_offset;
						o.write_data = r.data_byte;
						buf_offset = buf_offset + 1'b1;
					end
				end
				IN_SOURCE: begin
					// Any byte is a source, framing characters included
					src_id = r.data_byte - ID_BIAS;
					msg_phase = IN_DEST;
				end
				IN_DEST: begin
					if (r.data_byte == CH_SLASH)
						msg_phase = IN_FIELDS;
					else if (r.data_byte == CH_CLOSE)
						msg_phase = FINISHED;
					else
						dst_id = r.data_byte - ID_BIAS;
				end
				IN_FIELDS: begin
					if (delim) begin
						if (room) begin
							o.write_kind = WK_FIELD;
							o.field_index = field_no[2:0];
							o.write_offset = buf_offset;
						end else begin
							o.overflow = 1'b1;
						end
						if (r.data_byte == CH_SLASH) begin
							// Field index saturates at the field count
							if (room)
								field_no = field_no + 1'b1;
							buf_offset = '0;
						end else begin
							msg_phase = FINISHED;
						end
					end else if (!room || buf_offset >= FIELD_LEN - 1) begin
						o.overflow = 1'b1;
					end else begin
						o.write_kind = WK_FIELD;
						o.field_index = field_no[2:0];
						o.write_offset = buf_offset;
						o.write_data = r.data_byte;
						buf_offset = buf_offset + 1'b1;
					end
				end
				default: ;
			endcase
		end
		o.source_id = src_id;
		o.dest_id = dst_id;
		o.done_res = msg_phase == FINISHED;
		return o;
	endfunction

	function automatic bit field_differs(string name, int unsigned want, int unsigned got);
		if (want != got)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return want != got;
	endfunction

	// Mostly short gaps, some medium, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_byte(bit no_slash, bit no_close);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((no_slash && b == CH_SLASH) || (no_close && b == CH_CLOSE));
		return b;
	endfunction

	task automatic add_byte(logic [7:0] b);
		pending_req.push_back('{cmd: CMD_PARSE, data_byte: b});
	endtask

	task automatic add_restart();
		// Payload byte is a don't-care on restart; randomize it anyway
		pending_req.push_back('{cmd: CMD_RESTART, data_byte: 8'($urandom_range(0, 255))});
	endtask

	// Queue one framed message with random content; mostly well formed, with
	// the occasional long command, long field, field pile-up or early restart.
	task automatic add_message();
		int n_lead;
		int n_cmd;
		int n_dest;
		int n_fields;
		int n_chars;
		n_lead = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
		repeat (n_lead)
			add_byte(pick_byte(1'b0, 1'b0));
		add_byte(CH_OPEN);
		n_cmd = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(13, 18);
		repeat (n_cmd)
			add_byte(pick_byte(1'b1, 1'b0));
		if ($urandom_range(0, 99) < 8) begin
			// Abandon the message halfway
			add_restart();
			return;
		end
		add_byte(CH_SLASH);
		add_byte(pick_byte(1'b0, 1'b0));
		n_dest = $urandom_range(0, 3);
		repeat (n_dest)
			add_byte(pick_byte(1'b1, 1'b1));
		if ($urandom_range(0, 99) < 25) begin
			add_byte(CH_CLOSE);
		end else begin
			add_byte(CH_SLASH);
			n_fields = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
				: $urandom_range(7, 11);
			for (int f = 0; f < n_fields; f++) begin
				if (f != 0)
					add_byte(CH_SLASH);
				n_chars = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
					: $urandom_range(14, 18);
				repeat (n_chars)
					add_byte(pick_byte(1'b1, 1'b1));
			end
			add_byte(CH_CLOSE);
		end
		// Bytes after the close are ignored until restart
		repeat ($urandom_range(0, 2))
			add_byte(pick_byte(1'b0, 1'b0));
		if ($urandom_range(0, 99) < 92)
			add_restart();
	endtask

	// Request driver: hold the payload while stalled, otherwise pop the next
	// pending request after the chosen gap. Predict on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp.push_back(parse_step(req));
			if (req_valid && !req_ready) begin
				// hold: payload and valid stay put until accepted
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_req.size() != 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
				send_gap <= calm ? 0 : pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor: compare each taken transaction with the oldest
	// prediction, then decide whether to stall the next cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_stall = 0;
			hold_left = 0;
			hold_done = 1'b0;
			rsp_seen = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with nothing outstanding, actual %p", $time, rsp);
					errors++;
				end else begin
					rsp_t want;
					want = expected_rsp.pop_front();
					if (field_differs("write_kind", want.write_kind, rsp.write_kind)
						| field_differs("field_index", want.field_index, rsp.field_index)
						| field_differs("write_offset", want.write_offset, rsp.write_offset)
						| field_differs("write_data", want.write_data, rsp.write_data)
						| field_differs("source_id", want.source_id, rsp.source_id)
						| field_differs("dest_id", want.dest_id, rsp.dest_id)
						| field_differs("done_res", want.done_res, rsp.done_res)
						| field_differs("overflow", want.overflow, rsp.overflow))
						errors++;
				end
				if (!calm)
					recv_stall = pick_gap();
			end
			// Long hold once: back the block up so it drops req_ready
			if (rsp_seen == HOLD_AT && !hold_done) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		errors = 0;

		// Directed: ignored byte before start, a full message with an empty
		// field, a byte in the done phase, an empty command, framing bytes as
		// source and destination end, and a source that wraps below 48.
		add_byte(8'h41);
		add_byte(CH_OPEN);
		add_byte(8'h41);
		add_byte(8'hFF);
		add_byte(CH_SLASH);
		add_byte(8'h33);
		add_byte(8'h34);
		add_byte(8'h35);
		add_byte(CH_SLASH);
		add_byte(8'h61);
		add_byte(CH_SLASH);
		add_byte(CH_SLASH);
		add_byte(8'h80);
		add_byte(CH_CLOSE);
		add_byte(CH_OPEN);
		add_restart();
		add_byte(CH_OPEN);
		add_byte(CH_SLASH);
		add_byte(CH_SLASH);
		add_byte(CH_CLOSE);
		add_restart();
		add_byte(CH_OPEN);
		add_byte(CH_SLASH);
		add_byte(8'h00);
		add_byte(8'h7F);

		// Random: well-formed messages with random content, sprinkled with
		// stray bytes and restarts in arbitrary places.
		add_restart();
		while (pending_req.size() < MSG_ITEMS) begin
			if ($urandom_range(0, 99) < 10)
				pending_req.push_back('{cmd: logic'($urandom_range(0, 1)),
					data_byte: 8'($urandom_range(0, 255))});
			else
				add_message();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait until every request is sent and every response checked
		while (!(pending_req.size() == 0 && !req_valid && expected_rsp.size() == 0)
			&& idle_cycles < IDLE_LIMIT)
			@(negedge clk);

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d requests pending, %0d responses outstanding",
				$time, pending_req.size(), expected_rsp.size());
			$display("== FAIL ==");
		end else begin
			repeat (DRAIN_SLACK) @(negedge clk);
			if (errors == 0)
				$display("== PASS ==");
			else
				$display("== FAIL ==");
		end
		$finish;
	end

endmodule
